### hdl/i2cmts_pkg.sv
// ----------------------------------------------------------------------------
// i2cmts_pkg
// types and constants shared by the i2c master transfer sequencer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package i2cmts_pkg;

    // operation codes of an input item
    localparam logic [1:0] OP_TX_REQ = 2'd0;
    localparam logic [1:0] OP_RX_REQ = 2'd1;
    localparam logic [1:0] OP_EVENT  = 2'd2;

    // status flag bit positions
    localparam int FL_SB   = 0;
    localparam int FL_ADDR = 1;
    localparam int FL_BTF  = 2;
    localparam int FL_STOPF = 3;
    localparam int FL_TXE  = 4;
    localparam int FL_RXNE = 5;
    localparam int FL_MSL  = 6;
    localparam int FL_TRA  = 7;

    // notify bit positions
    localparam int NT_TX_DONE = 0;
    localparam int NT_RX_DONE = 1;
    localparam int NT_STOP    = 2;
    localparam int NT_DATA_REQ = 3;
    localparam int NT_DATA_RCV = 4;

    localparam int LENGTH_W = 16;

    typedef enum logic [1:0] {
        MODE_READY = 2'd0,
        MODE_TX    = 2'd1,
        MODE_RX    = 2'd2
    } t_mode;

    typedef struct packed {
        logic [1:0]          operation;
        logic [LENGTH_W-1:0] length;
        logic [6:0]          slave_addr;
        logic                keep_bus;
        logic [7:0]          status_flags;
        logic [7:0]          rx_byte;
        logic [7:0]          tx_byte;
    } t_in_item;

    typedef struct packed {
        logic [1:0] prior_state;
        logic       dr_write;
        logic [7:0] dr_value;
        logic       tx_consumed;
        logic       rx_store;
        logic       start_req;
        logic       stop_req;
        logic       ack_on;
        logic       irq_on;
        logic [4:0] notify;
    } t_out_item;

    // sequencer control state apart from the byte counters
    typedef struct packed {
        t_mode      mode;
        logic [6:0] target_addr;
        logic       hold_bus;
        logic       ack_level;
        logic       irq_enabled;
    } t_ctrl;

endpackage

`default_nettype wire

### hdl/i2c_master_irq_transfer_sequencer.sv
// ----------------------------------------------------------------------------
// i2c_master_irq_transfer_sequencer
// interrupt-driven i2c master transfer sequencer: requests and status events
// in, data register / condition / notify actions out
// ----------------------------------------------------------------------------
//
// channel | direction | handshake                     | payload
// --------+-----------+-------------------------------+-------------------
// in      | input     | i_in_valid / o_in_ready       | i_in_item (t_in_item)
// out     | output    | o_out_valid / i_out_ready     | o_out_item (t_out_item)
// cfg     | input     | i_cfg_valid / o_cfg_ready     | i_cfg_data (ack_default_on)
//
// every item gives exactly one result, staged through the input register and
// then the result register; the two registers let a new item in every cycle
// while the output side is not stalled, with the single step logic between them
// a stalled output holds the result register and the input register, and
// ready falls only when both are full
// synchronous active-low reset: idle, counters zero, ack_default_on set
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module i2c_master_irq_transfer_sequencer #(
    parameter int LEN_BITS = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  var i2cmts_pkg::t_in_item   i_in_item,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output i2cmts_pkg::t_out_item      o_out_item,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic                  i_cfg_data
);

    // input register
    logic                  r_in_valid;
    i2cmts_pkg::t_in_item  r_in_item;

    // sequencer state
    i2cmts_pkg::t_ctrl     r_ctrl;
    logic [LEN_BITS-1:0]   r_tx_left;
    logic [LEN_BITS-1:0]   r_rx_left;
    logic [LEN_BITS-1:0]   r_rx_total;
    logic                  r_ack_default_on;

    // result register
    logic                  r_out_valid;
    i2cmts_pkg::t_out_item r_out_item;

    // step outputs
    i2cmts_pkg::t_ctrl     n_ctrl;
    logic [LEN_BITS-1:0]   n_tx_left;
    logic [LEN_BITS-1:0]   n_rx_left;
    logic [LEN_BITS-1:0]   n_rx_total;
    i2cmts_pkg::t_out_item n_out_item;

    logic advance;
    logic in_take;

    // the staged item moves on when the result register is free or emptying
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign in_take    = i_in_valid && o_in_ready;

    assign o_cfg_ready = 1'b1;

    i2cmts_step #(
        .LEN_BITS (LEN_BITS)
    ) u_step (
        .i_item           (r_in_item),
        .i_ctrl           (r_ctrl),
        .i_tx_left        (r_tx_left),
        .i_rx_left        (r_rx_left),
        .i_rx_total       (r_rx_total),
        .i_ack_default_on (r_ack_default_on),
        .o_ctrl           (n_ctrl),
        .o_tx_left        (n_tx_left),
        .o_rx_left        (n_rx_left),
        .o_rx_total       (n_rx_total),
        .o_result         (n_out_item)
    );

    // control: valid flags and sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid       <= 1'b0;
            r_out_valid      <= 1'b0;
            r_ctrl           <= '{mode: i2cmts_pkg::MODE_READY, target_addr: '0,
                                  hold_bus: 1'b0, ack_level: 1'b0, irq_enabled: 1'b0};
            r_tx_left        <= '0;
            r_rx_left        <= '0;
            r_rx_total       <= '0;
            r_ack_default_on <= 1'b1;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end

            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            // state moves only when the staged item is processed
            if (advance) begin
                r_ctrl     <= n_ctrl;
                r_tx_left  <= n_tx_left;
                r_rx_left  <= n_rx_left;
                r_rx_total <= n_rx_total;
            end

            if (i_cfg_valid) begin
                r_ack_default_on <= i_cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_item <= i_in_item;
        end
        if (advance) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

`default_nettype wire

### hdl/i2cmts_step.sv
// ----------------------------------------------------------------------------
// i2cmts_step
// next-state and result logic for one request or status event
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module i2cmts_step #(
    parameter int LEN_BITS = 16
) (
    input  var i2cmts_pkg::t_in_item  i_item,
    input  var i2cmts_pkg::t_ctrl     i_ctrl,
    input  wire logic [LEN_BITS-1:0]  i_tx_left,
    input  wire logic [LEN_BITS-1:0]  i_rx_left,
    input  wire logic [LEN_BITS-1:0]  i_rx_total,
    input  wire logic                 i_ack_default_on,
    output i2cmts_pkg::t_ctrl         o_ctrl,
    output logic [LEN_BITS-1:0]       o_tx_left,
    output logic [LEN_BITS-1:0]       o_rx_left,
    output logic [LEN_BITS-1:0]       o_rx_total,
    output i2cmts_pkg::t_out_item     o_result
);

    logic [LEN_BITS-1:0]   len_w;
    logic [7:0]            fl;
    i2cmts_pkg::t_ctrl     n_ctrl;
    logic [LEN_BITS-1:0]   n_tx_left;
    logic [LEN_BITS-1:0]   n_rx_left;
    logic [LEN_BITS-1:0]   n_rx_total;
    i2cmts_pkg::t_out_item res;

    assign len_w = LEN_BITS'(i_item.length);
    assign fl    = i_item.status_flags;

    always_comb begin
        n_ctrl     = i_ctrl;
        n_tx_left  = i_tx_left;
        n_rx_left  = i_rx_left;
        n_rx_total = i_rx_total;
        res        = '0;
        res.prior_state = i_ctrl.mode;

        if ((i_item.operation == i2cmts_pkg::OP_TX_REQ ||
             i_item.operation == i2cmts_pkg::OP_RX_REQ) &&
            i_ctrl.mode == i2cmts_pkg::MODE_READY) begin
            if (i_item.operation == i2cmts_pkg::OP_TX_REQ) begin
                n_tx_left   = len_w;
                n_ctrl.mode = i2cmts_pkg::MODE_TX;
            end else begin
                n_rx_left   = len_w;
                n_rx_total  = len_w;
                n_ctrl.mode = i2cmts_pkg::MODE_RX;
            end
            n_ctrl.target_addr = i_item.slave_addr;
            n_ctrl.hold_bus    = i_item.keep_bus;
            n_ctrl.irq_enabled = 1'b1;
            res.start_req      = 1'b1;
        end else if (i_item.operation == i2cmts_pkg::OP_EVENT && i_ctrl.irq_enabled) begin
            // start sent: address byte with r/w bit
            if (fl[i2cmts_pkg::FL_SB]) begin
                if (i_ctrl.mode == i2cmts_pkg::MODE_TX) begin
                    res.dr_write = 1'b1;
                    res.dr_value = {i_ctrl.target_addr, 1'b0};
                end else if (i_ctrl.mode == i2cmts_pkg::MODE_RX) begin
                    res.dr_write = 1'b1;
                    res.dr_value = {i_ctrl.target_addr, 1'b1};
                end
            end
            // one-byte read: nack the only byte
            if (fl[i2cmts_pkg::FL_ADDR] && fl[i2cmts_pkg::FL_MSL] &&
                i_ctrl.mode == i2cmts_pkg::MODE_RX && i_rx_total == LEN_BITS'(1)) begin
                n_ctrl.ack_level = 1'b0;
            end
            // transmit finished
            if (fl[i2cmts_pkg::FL_BTF] && i_ctrl.mode == i2cmts_pkg::MODE_TX &&
                fl[i2cmts_pkg::FL_TXE] && i_tx_left == '0) begin
                res.stop_req       = ~i_ctrl.hold_bus;
                n_ctrl.irq_enabled = 1'b0;
                n_ctrl.mode        = i2cmts_pkg::MODE_READY;
                n_tx_left          = '0;
                res.notify[i2cmts_pkg::NT_TX_DONE] = 1'b1;
            end
            if (fl[i2cmts_pkg::FL_STOPF]) begin
                res.notify[i2cmts_pkg::NT_STOP] = 1'b1;
            end
            // transmit empty: feed the next byte or pass on a slave request
            if (fl[i2cmts_pkg::FL_TXE]) begin
                if (fl[i2cmts_pkg::FL_MSL]) begin
                    if (n_ctrl.mode == i2cmts_pkg::MODE_TX && n_tx_left != '0) begin
                        res.dr_write    = 1'b1;
                        res.dr_value    = i_item.tx_byte;
                        res.tx_consumed = 1'b1;
                        n_tx_left       = n_tx_left - LEN_BITS'(1);
                    end
                end else if (fl[i2cmts_pkg::FL_TRA]) begin
                    res.notify[i2cmts_pkg::NT_DATA_REQ] = 1'b1;
                end
            end
            // receive full
            if (fl[i2cmts_pkg::FL_RXNE]) begin
                if (fl[i2cmts_pkg::FL_MSL]) begin
                    if (n_ctrl.mode == i2cmts_pkg::MODE_RX) begin
                        if (i_rx_total == LEN_BITS'(1)) begin
                            res.rx_store = 1'b1;
                            n_rx_left    = i_rx_left - LEN_BITS'(1);
                        end
                        if (i_rx_total > LEN_BITS'(1)) begin
                            if (i_rx_left == LEN_BITS'(2)) begin
                                n_ctrl.ack_level = 1'b0;
                            end
                            res.rx_store = 1'b1;
                            n_rx_left    = i_rx_left - LEN_BITS'(1);
                        end
                        if (n_rx_left == '0) begin
                            res.stop_req       = ~i_ctrl.hold_bus;
                            n_ctrl.irq_enabled = 1'b0;
                            n_ctrl.mode        = i2cmts_pkg::MODE_READY;
                            n_rx_left          = '0;
                            n_rx_total         = '0;
                            if (i_ack_default_on) begin
                                n_ctrl.ack_level = 1'b1;
                            end
                            res.notify[i2cmts_pkg::NT_RX_DONE] = 1'b1;
                        end
                    end
                end else if (!fl[i2cmts_pkg::FL_TRA]) begin
                    res.notify[i2cmts_pkg::NT_DATA_RCV] = 1'b1;
                end
            end
        end

        res.ack_on = n_ctrl.ack_level;
        res.irq_on = n_ctrl.irq_enabled;
    end

    assign o_ctrl     = n_ctrl;
    assign o_tx_left  = n_tx_left;
    assign o_rx_left  = n_rx_left;
    assign o_rx_total = n_rx_total;
    assign o_result   = res;

endmodule

`default_nettype wire

### dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the i2c master transfer sequencer: directed
// transfers and corner cases, then random well-formed transfers mixed with
// noise, each result checked field by field against a local predictor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module testbench;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 10;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 1000;  // cycles with no handshake at all
    localparam int PHASE_ITEMS    = 200;
    localparam int PHASE_COUNT    = 8;
    localparam int REPORT_LIMIT   = 10;
    localparam int LEN_W          = i2cmts_pkg::LENGTH_W;

    // status flag masks built from the package bit positions
    localparam logic [7:0] EV_SB    = 8'h01 << i2cmts_pkg::FL_SB;
    localparam logic [7:0] EV_ADDR  = 8'h01 << i2cmts_pkg::FL_ADDR;
    localparam logic [7:0] EV_BTF   = 8'h01 << i2cmts_pkg::FL_BTF;
    localparam logic [7:0] EV_STOPF = 8'h01 << i2cmts_pkg::FL_STOPF;
    localparam logic [7:0] EV_TXE   = 8'h01 << i2cmts_pkg::FL_TXE;
    localparam logic [7:0] EV_RXNE  = 8'h01 << i2cmts_pkg::FL_RXNE;
    localparam logic [7:0] EV_MSL   = 8'h01 << i2cmts_pkg::FL_MSL;
    localparam logic [7:0] EV_TRA   = 8'h01 << i2cmts_pkg::FL_TRA;

    logic                  i_clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    i2cmts_pkg::t_in_item  in_item = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    i2cmts_pkg::t_out_item out_item;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic                  cfg_data = 1'b0;

    // sequencer state as the predictor sees it
    i2cmts_pkg::t_mode   pred_mode;
    logic [LEN_W-1:0]    pred_tx_left;
    logic [LEN_W-1:0]    pred_rx_left;
    logic [LEN_W-1:0]    pred_rx_total;
    logic [6:0]          pred_addr;
    logic                pred_hold;
    logic                pred_ack;
    logic                pred_irq;
    logic                pred_ack_default;

    i2cmts_pkg::t_out_item expected_results[$];
    int        mismatch_count = 0;
    int        idle_cycles = 0;
    int        seq_items = 0;
    int        in_idle_pct = 0;
    int        out_idle_pct = 0;
    int        stall_left = 0;

    i2c_master_irq_transfer_sequencer dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // predictor: one input item in, one expected result out
    // ------------------------------------------------------------------------

    function automatic i2cmts_pkg::t_out_item sequencer_step(i2cmts_pkg::t_in_item it);
        i2cmts_pkg::t_out_item r;
        logic [7:0] fl;
        r = '0;
        fl = it.status_flags;
        r.prior_state = pred_mode;
        if ((it.operation == i2cmts_pkg::OP_TX_REQ || it.operation == i2cmts_pkg::OP_RX_REQ)
                && pred_mode == i2cmts_pkg::MODE_READY) begin
            if (it.operation == i2cmts_pkg::OP_TX_REQ) begin
                pred_tx_left = it.length;
                pred_mode = i2cmts_pkg::MODE_TX;
            end else begin
                pred_rx_left = it.length;
                pred_rx_total = it.length;
                pred_mode = i2cmts_pkg::MODE_RX;
            end
            pred_addr = it.slave_addr;
            pred_hold = it.keep_bus;
            r.start_req = 1'b1;
            pred_irq = 1'b1;
        end else if (it.operation == i2cmts_pkg::OP_EVENT && pred_irq) begin
            // address byte with the r/w bit once the start is out
            if (fl[i2cmts_pkg::FL_SB] && pred_mode == i2cmts_pkg::MODE_TX) begin
                r.dr_write = 1'b1;
                r.dr_value = {pred_addr, 1'b0};
            end else if (fl[i2cmts_pkg::FL_SB] && pred_mode == i2cmts_pkg::MODE_RX) begin
                r.dr_write = 1'b1;
                r.dr_value = {pred_addr, 1'b1};
            end
            // single-byte read: nack the only byte
            if (fl[i2cmts_pkg::FL_ADDR] && fl[i2cmts_pkg::FL_MSL]
                    && pred_mode == i2cmts_pkg::MODE_RX && pred_rx_total == 1)
                pred_ack = 1'b0;
            // transmit end: later handlers still run against the new mode
            if (fl[i2cmts_pkg::FL_BTF] && pred_mode == i2cmts_pkg::MODE_TX
                    && fl[i2cmts_pkg::FL_TXE] && pred_tx_left == 0) begin
                r.stop_req = !pred_hold;
                pred_irq = 1'b0;
                pred_mode = i2cmts_pkg::MODE_READY;
                r.notify[i2cmts_pkg::NT_TX_DONE] = 1'b1;
            end
            if (fl[i2cmts_pkg::FL_STOPF])
                r.notify[i2cmts_pkg::NT_STOP] = 1'b1;
            if (fl[i2cmts_pkg::FL_TXE]) begin
                if (fl[i2cmts_pkg::FL_MSL]) begin
                    if (pred_mode == i2cmts_pkg::MODE_TX && pred_tx_left != 0) begin
                        r.dr_write = 1'b1;
                        r.dr_value = it.tx_byte;
                        r.tx_consumed = 1'b1;
                        pred_tx_left = pred_tx_left - 1'b1;
                    end
                end else if (fl[i2cmts_pkg::FL_TRA]) begin
                    r.notify[i2cmts_pkg::NT_DATA_REQ] = 1'b1;
                end
            end
            if (fl[i2cmts_pkg::FL_RXNE]) begin
                if (fl[i2cmts_pkg::FL_MSL]) begin
                    if (pred_mode == i2cmts_pkg::MODE_RX) begin
                        if (pred_rx_total == 1) begin
                            r.rx_store = 1'b1;
                            pred_rx_left = pred_rx_left - 1'b1;
                        end
                        if (pred_rx_total > 1) begin
                            if (pred_rx_left == 2)
                                pred_ack = 1'b0;
                            r.rx_store = 1'b1;
                            pred_rx_left = pred_rx_left - 1'b1;
                        end
                        // a zero-length read closes here with nothing stored
                        if (pred_rx_left == 0) begin
                            r.stop_req = !pred_hold;
                            pred_irq = 1'b0;
                            pred_mode = i2cmts_pkg::MODE_READY;
                            pred_rx_total = '0;
                            if (pred_ack_default)
                                pred_ack = 1'b1;
                            r.notify[i2cmts_pkg::NT_RX_DONE] = 1'b1;
                        end
                    end
                end else if (!fl[i2cmts_pkg::FL_TRA]) begin
                    r.notify[i2cmts_pkg::NT_DATA_RCV] = 1'b1;
                end
            end
        end
        r.ack_on = pred_ack;
        r.irq_on = pred_irq;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------------

    function automatic void compare_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            if (mismatch_count < REPORT_LIMIT)
                $display("%0t: mismatch in %s: expected %0h, actual %0h",
                         $realtime, name, want, got);
            mismatch_count++;
        end
    endfunction

    function automatic void check_result(i2cmts_pkg::t_out_item got);
        i2cmts_pkg::t_out_item want;
        if (expected_results.size() == 0) begin
            if (mismatch_count < REPORT_LIMIT)
                $display("%0t: result with nothing pending: %p", $realtime, got);
            mismatch_count++;
            return;
        end
        want = expected_results.pop_front();
        compare_field("prior_state", want.prior_state, got.prior_state);
        compare_field("dr_write",    want.dr_write,    got.dr_write);
        compare_field("dr_value",    want.dr_value,    got.dr_value);
        compare_field("tx_consumed", want.tx_consumed, got.tx_consumed);
        compare_field("rx_store",    want.rx_store,    got.rx_store);
        compare_field("start_req",   want.start_req,   got.start_req);
        compare_field("stop_req",    want.stop_req,    got.stop_req);
        compare_field("ack_on",      want.ack_on,      got.ack_on);
        compare_field("irq_on",      want.irq_on,      got.irq_on);
        compare_field("notify",      want.notify,      got.notify);
    endfunction

    // a gap with chance pct: mostly a short one, now and then a long one
    function automatic int pick_gap(int pct);
        if ($urandom_range(0, 99) >= pct)
            return 0;
        if ($urandom_range(0, 7) == 0)
            return $urandom_range(12, 40);
        return $urandom_range(1, 3);
    endfunction

    // result side: check each accepted item, then decide the next ready level
    always @(posedge i_clk) begin
        if (rst_n && out_valid && out_ready)
            check_result(out_item);
        if (stall_left > 0) begin
            stall_left--;
            out_ready <= 1'b0;
        end else begin
            stall_left = pick_gap(out_idle_pct);
            out_ready <= (stall_left == 0);
            if (stall_left > 0)
                stall_left--;
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("testbench failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    // every field random, so unused fields still toggle
    function automatic i2cmts_pkg::t_in_item random_item();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[$bits(i2cmts_pkg::t_in_item)-1:0];
    endfunction

    task automatic send_item(i2cmts_pkg::t_in_item it);
        int gap;
        gap = pick_gap(in_idle_pct);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        expected_results.push_back(sequencer_step(it));
    endtask

    task automatic send_event(logic [7:0] flags, logic [7:0] rx, logic [7:0] tx);
        i2cmts_pkg::t_in_item it;
        it = random_item();
        it.operation = i2cmts_pkg::OP_EVENT;
        it.status_flags = flags;
        it.rx_byte = rx;
        it.tx_byte = tx;
        seq_items++;
        send_item(it);
    endtask

    task automatic send_request(logic [1:0] op, logic [LEN_W-1:0] len,
                                logic [6:0] addr, logic keep);
        i2cmts_pkg::t_in_item it;
        it = random_item();
        it.operation = op;
        it.length = len;
        it.slave_addr = addr;
        it.keep_bus = keep;
        seq_items++;
        send_item(it);
    endtask

    // sender holds off until every pending result is back, then lets it settle
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_ack_default(logic value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        cfg_valid <= 1'b0;
        pred_ack_default = value;
    endtask

    // random op, small lengths so a stray request cannot lock the block for long
    task automatic maybe_noise();
        i2cmts_pkg::t_in_item it;
        if ($urandom_range(0, 7) == 0) begin
            it = random_item();
            if (it.operation != i2cmts_pkg::OP_EVENT)
                it.length = LEN_W'($urandom_range(0, 6));
            send_item(it);
        end
    endtask

    // one request walked to its end with the events a real bus would give
    task automatic run_transfer();
        logic                is_read;
        logic [LEN_W-1:0]    len;
        logic [7:0]          tra;
        logic [7:0]          flags;
        int                  steps;
        is_read = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 9) == 0)
            len = LEN_W'($urandom_range(5, 40));
        else
            len = LEN_W'($urandom_range(0, 4));
        tra = is_read ? 8'h00 : EV_TRA;
        maybe_noise();
        send_request(is_read ? i2cmts_pkg::OP_RX_REQ : i2cmts_pkg::OP_TX_REQ, len,
                     7'($urandom), 1'($urandom));
        if (!is_read && $urandom_range(0, 3) == 0)
            send_event(EV_SB | EV_TXE | EV_MSL | EV_TRA, 8'($urandom), 8'($urandom));
        else
            send_event(EV_SB | EV_MSL | tra, 8'($urandom), 8'($urandom));
        maybe_noise();
        send_event(EV_ADDR | EV_MSL | tra, 8'($urandom), 8'($urandom));
        steps = 0;
        while (pred_mode != i2cmts_pkg::MODE_READY && steps < 100) begin
            maybe_noise();
            case (pred_mode)
                i2cmts_pkg::MODE_TX: flags = (pred_tx_left != 0)
                                           ? (EV_TXE | EV_MSL | EV_TRA)
                                           : (EV_BTF | EV_TXE | EV_MSL | EV_TRA);
                i2cmts_pkg::MODE_RX: flags = EV_RXNE | EV_MSL
                                           | ($urandom_range(0, 1) ? EV_TRA : 8'h00);
                default: flags = 8'($urandom);
            endcase
            // slave-side events show up now and then
            if ($urandom_range(0, 9) == 0)
                flags = $urandom_range(0, 1) ? (EV_TXE | EV_TRA) : EV_RXNE;
            if ($urandom_range(0, 7) == 0)
                flags = flags | EV_STOPF;
            send_event(flags, 8'($urandom), 8'($urandom));
            steps++;
        end
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // events with interrupts off and the unused operation code do nothing
    task automatic test_ignored_items();
        i2cmts_pkg::t_in_item it;
        send_event(8'hFF, 8'hFF, 8'hFF);
        it = random_item();
        it.operation = 2'b11;
        send_item(it);
    endtask

    // two-byte write, start and first byte in one event: the data byte wins the data register
    task automatic test_transmit();
        send_request(i2cmts_pkg::OP_TX_REQ, 16'd2, 7'h7F, 1'b0);
        send_event(EV_SB | EV_TXE | EV_MSL | EV_TRA, 8'h00, 8'hFF);
        send_request(i2cmts_pkg::OP_RX_REQ, 16'd3, 7'h12, 1'b1);  // busy, ignored
        send_event(EV_ADDR | EV_MSL | EV_TRA, 8'hFF, 8'h00);
        send_event(EV_TXE | EV_MSL | EV_TRA, 8'h00, 8'h00);
        send_event(EV_BTF | EV_TXE | EV_MSL | EV_TRA | EV_STOPF, 8'h00, 8'hA5);
    endtask

    // zero-length write with the bus kept: closes with no stop
    task automatic test_empty_transmit();
        send_request(i2cmts_pkg::OP_TX_REQ, 16'd0, 7'h00, 1'b1);
        send_event(EV_SB | EV_MSL | EV_TRA, 8'h00, 8'h00);
        send_event(EV_BTF | EV_TXE | EV_MSL | EV_TRA, 8'h00, 8'h3C);
    endtask

    // one-byte read: nack at address time, ack back on at the close
    task automatic test_single_read();
        send_request(i2cmts_pkg::OP_RX_REQ, 16'd1, 7'h55, 1'b0);
        send_event(EV_SB | EV_MSL, 8'h00, 8'h00);
        send_event(EV_ADDR | EV_MSL, 8'h00, 8'h00);
        send_event(EV_RXNE | EV_MSL, 8'hFF, 8'h00);
    endtask

    // three-byte read with slave notifications in between
    task automatic test_read_with_slave_events();
        send_request(i2cmts_pkg::OP_RX_REQ, 16'd3, 7'h2A, 1'b1);
        send_event(EV_TXE | EV_TRA, 8'h00, 8'h00);
        send_event(EV_RXNE, 8'h81, 8'h00);
        send_event(EV_RXNE | EV_MSL, 8'h01, 8'h00);
        send_event(EV_RXNE | EV_MSL | EV_TRA, 8'h80, 8'h00);  // nack at two left
        send_event(EV_RXNE | EV_MSL, 8'h7E, 8'h00);
    endtask

    // zero-length read: first master rx-full closes with nothing stored
    task automatic test_empty_read();
        send_request(i2cmts_pkg::OP_RX_REQ, 16'd0, 7'h01, 1'b0);
        send_event(EV_RXNE | EV_MSL, 8'hC3, 8'h00);
    endtask

    // with the default off the ack stays low after a one-byte read
    task automatic test_ack_default_off();
        write_ack_default(1'b0);
        send_request(i2cmts_pkg::OP_RX_REQ, 16'd1, 7'h40, 1'b0);
        send_event(EV_ADDR | EV_MSL, 8'h00, 8'h00);
        send_event(EV_RXNE | EV_MSL, 8'h5A, 8'h00);
        write_ack_default(1'b1);
    endtask

    // phases of random transfers, each setting its idling and register value at its start
    task automatic test_random_transfers();
        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            if (phase < 2)
                write_ack_default(phase[0]);
            else
                write_ack_default(1'($urandom_range(0, 1)));
            case (phase % 4)
                0: begin in_idle_pct = 0;  out_idle_pct = 0;  end
                1: begin in_idle_pct = 20; out_idle_pct = 20; end
                2: begin in_idle_pct = 50; out_idle_pct = 10; end
                default: begin in_idle_pct = 10; out_idle_pct = 60; end
            endcase
            seq_items = 0;
            while (seq_items < PHASE_ITEMS)
                run_transfer();
        end
    endtask

    // full-scale read length: left unfinished, so it runs last
    task automatic test_long_read();
        wait_idle();
        in_idle_pct = 20;
        out_idle_pct = 20;
        send_request(i2cmts_pkg::OP_RX_REQ, 16'hFFFF, 7'($urandom), 1'b0);
        send_event(EV_SB | EV_MSL, 8'h00, 8'h00);
        repeat (10)
            send_event(EV_RXNE | EV_MSL, 8'($urandom), 8'($urandom));
        send_request(i2cmts_pkg::OP_TX_REQ, 16'hFFFF, 7'h7F, 1'b1);  // busy, ignored
    endtask

    initial begin
        pred_mode = i2cmts_pkg::MODE_READY;
        pred_tx_left = '0;
        pred_rx_left = '0;
        pred_rx_total = '0;
        pred_addr = '0;
        pred_hold = 1'b0;
        pred_ack = 1'b0;
        pred_irq = 1'b0;
        pred_ack_default = 1'b1;

        repeat (RESET_CYCLES) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        in_idle_pct = 30;
        out_idle_pct = 30;
        test_ignored_items();
        test_transmit();
        test_empty_transmit();
        test_single_read();
        test_read_with_slave_events();
        test_empty_read();
        test_ack_default_off();
        test_random_transfers();
        test_long_read();

        wait_idle();
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

`default_nettype wire
